[sv/clct_pkg.sv]
// ----------------------------------------------------------------------------
// clct_pkg
// Types, constants and helper functions shared by the leap-compensated
// timestamp block.
// ----------------------------------------------------------------------------
package clct_pkg;

  localparam int unsigned FREQ_W  = 40;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned NUM_W   = 84;
  localparam int unsigned DIV_CYC = NUM_W / 2;
  localparam int unsigned CNT_W   = $clog2(DIV_CYC);

  localparam logic [FREQ_W-1:0] FREQ_RST = 40'd10000000;
  localparam logic [THR_W-1:0]  THR_RST  = 16'd500;

  localparam logic [31:0] MS_PER_S = 32'd1000;
  localparam logic [31:0] US_PER_S = 32'd1000000;

  localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  localparam logic [1:0] REG_FREQ  = 2'd0;
  localparam logic [1:0] REG_THR   = 2'd1;
  localparam logic [1:0] REG_HIRES = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MS1_ISSUE,
    ST_MS1_WAIT,
    ST_DRIFT,
    ST_ADJ_WAIT,
    ST_ADJUST,
    ST_MS_ISSUE,
    ST_MS_WAIT,
    ST_US_WAIT,
    ST_FINISH
  } seq_state_e;

  typedef enum logic [2:0] {
    MU_IDLE,
    MU_MUL_LO,
    MU_MUL_HI,
    MU_MUL_ACC,
    MU_DIV
  } mu_state_e;

  typedef struct packed {
    logic              start;
    logic [63:0]       a;
    logic [31:0]       b;
    logic [FREQ_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } md_rsp_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [THR_W-1:0]  thr;
    logic              hires;
  } cfg_t;

  function automatic logic [63:0] neg64(input logic [63:0] x);
    return 64'(~x + 64'd1);
  endfunction

  function automatic logic [63:0] sat_conv(input logic [NUM_W-1:0] q, input logic neg);
    logic over;
    logic [63:0] res;
    if (!neg) begin
      over = |q[NUM_W-1:63];
      res  = over ? MAX64 : q[63:0];
    end else begin
      over = (|q[NUM_W-1:64]) || (q[63] && (|q[62:0]));
      res  = over ? SIGN64 : neg64(q[63:0]);
    end
    return res;
  endfunction

endpackage

[sv/counter_leap_compensated_timestamp.sv]
// ----------------------------------------------------------------------------
// counter_leap_compensated_timestamp
// Elapsed-time counter that checks a fast counter against a millisecond tick
// and shifts its reference start when the two drift apart.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: kind; tdata: fast_count, tick_ms
//  m_axis    out        tuser: leap_corrected; tdata: elapsed_count, _ms, _us
//  apb       in/out     counter_frequency, drift_threshold_ms, high_res_mode
//
// A capture or a fallback measure passes from idle straight to the finish state.
// A high-resolution measure runs a drift-check conversion, a shift conversion
// when the start is shifted, then the millisecond and microsecond conversions.
// Each conversion runs through the shared multiply-divide unit, two quotient
// bits per cycle over an 84-bit dividend.
// Reset clears the reference state and loads the register defaults.
// A finished result waits in the output register while the next transfer is
// accepted.
// ----------------------------------------------------------------------------
module counter_leap_compensated_timestamp (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // fast_count[62:0], tick_ms[94:63], zero pad
  input  logic [0:0]   s_axis_tuser,  // kind[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,  // elapsed_count, elapsed_ms, elapsed_us
  output logic [0:0]   m_axis_tuser,  // leap_corrected[0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import clct_pkg::*;

  cfg_t    cfg;
  md_req_t md_req;
  md_rsp_t md_rsp;

  seq_state_e state_q, state_d;

  logic [63:0] start_count_q;
  logic [31:0] start_tick_q;
  logic [63:0] last_elapsed_q;
  logic [63:0] diff_q;
  logic [31:0] tick_q;
  logic [31:0] lo32_q;
  logic        drift_neg_q;
  logic [63:0] grow_q;
  logic [63:0] adj_q;
  logic [63:0] res_count_q, res_ms_q, res_us_q;
  logic        res_leap_q;
  logic        m_valid_q;
  logic [191:0] m_data_q;
  logic        m_leap_q;

  logic              s_acc;
  logic              in_kind;
  logic [62:0]       in_fast;
  logic [31:0]       in_tick;
  logic [FREQ_W-1:0] freq_eff;
  logic [63:0]       abs_diff;
  logic [31:0]       d32, mag32;
  logic              leap_w;
  logic [63:0]       adj_sel;
  logic              out_free;

  clct_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  clct_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign in_kind = s_axis_tuser[0];
  assign in_fast = s_axis_tdata[62:0];
  assign in_tick = s_axis_tdata[94:63];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign freq_eff = (cfg.freq == '0) ? FREQ_W'(1) : cfg.freq;
  assign abs_diff = diff_q[63] ? neg64(diff_q) : diff_q;

  always_comb begin
    d32     = 32'(lo32_q - 32'(tick_q - start_tick_q));
    mag32   = d32[31] ? 32'(~d32 + 32'd1) : d32;
    leap_w  = (mag32 > {{(32-THR_W){1'b0}}, cfg.thr});
    adj_sel = ($signed(grow_q) < $signed(adj_q)) ? grow_q : adj_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = (!in_kind || !cfg.hires) ? ST_FINISH : ST_MS1_ISSUE;
        end
      end
      ST_MS1_ISSUE: state_d = ST_MS1_WAIT;
      ST_MS1_WAIT:  if (md_rsp.done) state_d = ST_DRIFT;
      ST_DRIFT:     state_d = leap_w ? ST_ADJ_WAIT : ST_MS_ISSUE;
      ST_ADJ_WAIT:  if (md_rsp.done) state_d = ST_ADJUST;
      ST_ADJUST:    state_d = ST_MS_ISSUE;
      ST_MS_ISSUE:  state_d = ST_MS_WAIT;
      ST_MS_WAIT:   if (md_rsp.done) state_d = ST_US_WAIT;
      ST_US_WAIT:   if (md_rsp.done) state_d = ST_FINISH;
      ST_FINISH:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    md_req = '0;
    unique case (state_q) inside
      ST_MS1_ISSUE, ST_MS_ISSUE: begin
        md_req.start = 1'b1;
        md_req.a     = abs_diff;
        md_req.b     = MS_PER_S;
        md_req.d     = freq_eff;
      end
      ST_DRIFT: begin
        md_req.start = leap_w;
        md_req.a     = {{(64-FREQ_W){1'b0}}, freq_eff};
        md_req.b     = mag32;
        md_req.d     = FREQ_W'(MS_PER_S);
      end
      ST_MS_WAIT: begin
        md_req.start = md_rsp.done;
        md_req.a     = abs_diff;
        md_req.b     = US_PER_S;
        md_req.d     = freq_eff;
      end
      default: md_req = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      start_count_q  <= '0;
      start_tick_q   <= '0;
      last_elapsed_q <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_acc && !in_kind) begin
        start_count_q  <= {1'b0, in_fast};
        start_tick_q   <= in_tick;
        last_elapsed_q <= '0;
      end
      if (state_q == ST_ADJUST) begin
        start_count_q <= 64'(start_count_q + adj_sel);
      end
      if (state_q == ST_MS_ISSUE) begin
        last_elapsed_q <= diff_q;
      end
      if (state_q == ST_FINISH && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          tick_q      <= in_tick;
          diff_q      <= 64'({1'b0, in_fast} - start_count_q);
          res_count_q <= '0;
          res_leap_q  <= 1'b0;
          if (!in_kind) begin
            res_ms_q <= '0;
            res_us_q <= '0;
          end else begin
            res_ms_q <= {32'd0, in_tick};
            res_us_q <= {32'd0, in_tick};
          end
        end
      end
      ST_MS1_WAIT: begin
        if (md_rsp.done) begin
          lo32_q <= diff_q[63] ? 32'(~md_rsp.quot[31:0] + 32'd1) : md_rsp.quot[31:0];
        end
      end
      ST_DRIFT: begin
        drift_neg_q <= d32[31];
        grow_q      <= 64'(diff_q - last_elapsed_q);
      end
      ST_ADJ_WAIT: begin
        if (md_rsp.done) begin
          adj_q <= drift_neg_q ? neg64(md_rsp.quot[63:0]) : md_rsp.quot[63:0];
        end
      end
      ST_ADJUST: begin
        diff_q     <= 64'(diff_q - adj_sel);
        res_leap_q <= 1'b1;
      end
      ST_MS_WAIT: begin
        if (md_rsp.done) begin
          res_ms_q <= sat_conv(md_rsp.quot, diff_q[63]);
        end
      end
      ST_US_WAIT: begin
        if (md_rsp.done) begin
          res_us_q    <= sat_conv(md_rsp.quot, diff_q[63]);
          res_count_q <= diff_q;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          m_data_q <= {res_us_q, res_ms_q, res_count_q};
          m_leap_q <= res_leap_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_leap_q;

endmodule

[sv/clct_muldiv.sv]
// ----------------------------------------------------------------------------
// clct_muldiv
// Shared multiply-divide unit: forms a * b from two 64-bit partial products,
// then divides by d with a restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module clct_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clct_pkg::md_req_t req_i,
  output clct_pkg::md_rsp_t rsp_o
);
  import clct_pkg::*;

  mu_state_e         state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [63:0]       a_q;
  logic [31:0]       b_q;
  logic [FREQ_W-1:0] d_q;
  logic [63:0]       pp_q;
  logic [NUM_W-1:0]  num_q;
  logic [FREQ_W-1:0] rem_q;

  logic [FREQ_W:0]   r1, r2;
  logic [FREQ_W-1:0] r1s, rem_d;
  logic              q1, q2;
  logic              last_step;

  assign last_step = (cnt_q == CNT_W'(DIV_CYC - 1));

  always_comb begin
    r1    = {rem_q, num_q[NUM_W-1]};
    q1    = (r1 >= {1'b0, d_q});
    r1s   = q1 ? FREQ_W'(r1 - {1'b0, d_q}) : r1[FREQ_W-1:0];
    r2    = {r1s, num_q[NUM_W-2]};
    q2    = (r2 >= {1'b0, d_q});
    rem_d = q2 ? FREQ_W'(r2 - {1'b0, d_q}) : r2[FREQ_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MU_IDLE:    if (req_i.start) state_d = MU_MUL_LO;
      MU_MUL_LO:  state_d = MU_MUL_HI;
      MU_MUL_HI:  state_d = MU_MUL_ACC;
      MU_MUL_ACC: state_d = MU_DIV;
      MU_DIV:     if (last_step) state_d = MU_IDLE;
      default:    state_d = MU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MU_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MU_DIV) && last_step;
      if (state_q == MU_DIV) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MU_IDLE: begin
        if (req_i.start) begin
          a_q <= req_i.a;
          b_q <= req_i.b;
          d_q <= req_i.d;
        end
      end
      MU_MUL_LO: pp_q <= a_q[31:0] * b_q;
      MU_MUL_HI: begin
        num_q <= {{(NUM_W-64){1'b0}}, pp_q};
        pp_q  <= a_q[63:32] * b_q;
      end
      MU_MUL_ACC: begin
        num_q <= NUM_W'(num_q + {pp_q[NUM_W-33:0], 32'd0});
        rem_q <= '0;
      end
      MU_DIV: begin
        num_q <= {num_q[NUM_W-3:0], q1, q2};
        rem_q <= rem_d;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

[sv/clct_cfg.sv]
// ----------------------------------------------------------------------------
// clct_cfg
// Register file for the timestamp block, written and read over the
// peripheral bus port.
// ----------------------------------------------------------------------------
module clct_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel_i,
  input  logic           penable_i,
  input  logic           pwrite_i,
  input  logic [4:0]     paddr_i,
  input  logic [63:0]    pwdata_i,
  output logic [63:0]    prdata_o,
  output logic           pready_o,
  output clct_pkg::cfg_t cfg_o
);
  import clct_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[4:3];
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.freq  <= FREQ_RST;
      cfg_q.thr   <= THR_RST;
      cfg_q.hires <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        REG_FREQ:  cfg_q.freq  <= pwdata_i[FREQ_W-1:0];
        REG_THR:   cfg_q.thr   <= pwdata_i[THR_W-1:0];
        REG_HIRES: cfg_q.hires <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FREQ:  prdata_o = {{(64-FREQ_W){1'b0}}, cfg_q.freq};
      REG_THR:   prdata_o = {{(64-THR_W){1'b0}}, cfg_q.thr};
      REG_HIRES: prdata_o = {63'd0, cfg_q.hires};
      default:   prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[sv/clct_checker.sv]
// ----------------------------------------------------------------------------
// clct_checker
// Port-level checks for the timestamp block, bound to its top level.
// ----------------------------------------------------------------------------
module clct_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         psel,
  input logic         pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_ms_us_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[127:64] != 64'd0) |->
      m_axis_tdata[127] == m_axis_tdata[191])
    else $error("milliseconds and microseconds disagree in sign");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("register port stalled");

endmodule

bind counter_leap_compensated_timestamp clct_checker u_clct_checker (.*);
